>>> sv/tde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie dictionary package
// Command codes and the sequencer state type shared by the dictionary engine.
// ----------------------------------------------------------------------------
package tde_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage
`default_nettype wire

>>> sv/tde_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie dictionary RAM
// Single-port synchronous RAM with a registered read and no reset.
// ----------------------------------------------------------------------------
module tde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

>>> sv/trie_dictionary_engine.sv
`default_nettype none
// A final letter accepted in ST_IDLE is executed in ST_EXEC, and its result is then
// registered into result_valid_q, found_q and status_q, which drive the ports.
// A new letter is not taken while the engine is in ST_EXEC with busy high; this is set
// by the read-modify-write of the child table through its single RAM port.
// Reset: a clearing pass writes every child entry with busy high.
// Results appear on the final letter only and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Trie dictionary engine
// Word dictionary kept as a letter trie in a node pool; insert, search and delete.
// ----------------------------------------------------------------------------
module trie_dictionary_engine
  import tde_pkg::*;
#(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command_i,
  input  wire logic [4:0] letter_i,
  input  wire logic       last_i,
  output logic            result_valid_o,
  output logic            found_o,
  output logic            status_o
);

  localparam int DEPTH  = NODES * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NODE_W = $clog2(NODES);
  localparam int FREE_W = $clog2(NODES + 1);
  localparam int ENT_W  = NODE_W + 1;

  localparam logic [ADDR_W-1:0] ALPHA_A   = ADDR_W'(ALPHABET);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [FREE_W-1:0] NODES_F   = FREE_W'(NODES);

  // Each entry holds a child pointer and the end mark of that child. Every node
  // but the root has exactly one parent entry, and a word never ends at the root.
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [NODE_W-1:0]   cur_q, cur_d;
  logic [FREE_W-1:0]   next_free_q, next_free_d;
  logic                path_lost_q, path_lost_d;
  logic                overflowed_q, overflowed_d;
  logic                result_valid_q, result_valid_d;
  logic                found_q, found_d;
  logic                status_q, status_d;

  logic [1:0]          cmd_q;
  logic                last_q;
  logic                bad_q;
  logic [ADDR_W-1:0]   addr_q;

  logic                letter_bad;
  logic [4:0]          letter_sel;
  logic [ADDR_W-1:0]   addr_calc;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;

  logic [NODE_W-1:0]   child;
  logic                mark;
  logic                is_insert;

  assign letter_bad = (32'(letter_i) >= ALPHABET);
  assign letter_sel = letter_bad ? 5'd0 : letter_i;
  assign addr_calc  = ADDR_W'(cur_q) * ALPHA_A + ADDR_W'(letter_sel);

  assign child     = ram_rdata[NODE_W-1:0];
  assign mark      = ram_rdata[NODE_W];
  assign is_insert = (cmd_q == CMD_INSERT);

  tde_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    cur_d          = cur_q;
    next_free_d    = next_free_q;
    path_lost_d    = path_lost_q;
    overflowed_d   = overflowed_q;
    result_valid_d = 1'b0;
    found_d        = found_q;
    status_d       = status_q;
    ram_we         = 1'b0;
    ram_addr       = addr_q;
    ram_wdata      = '0;
    busy           = 1'b1;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy     = 1'b0;
        ram_addr = addr_calc;
        if (start) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        if (is_insert) begin
          if (!overflowed_q) begin
            if (bad_q) begin
              overflowed_d = 1'b1;
            end else if (child == '0) begin
              if (next_free_q == NODES_F) begin
                overflowed_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                ram_wdata   = {last_q, next_free_q[NODE_W-1:0]};
                next_free_d = next_free_q + FREE_W'(1);
                cur_d       = next_free_q[NODE_W-1:0];
              end
            end else begin
              cur_d = child;
              if (last_q) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, child};
              end
            end
          end
        end else if (!path_lost_q) begin
          if (bad_q || child == '0 || FREE_W'(child) >= NODES_F) begin
            path_lost_d = 1'b1;
          end else begin
            cur_d = child;
          end
        end

        if (last_q) begin
          result_valid_d = 1'b1;
          if (is_insert) begin
            found_d  = 1'b1;
            status_d = overflowed_d;
          end else begin
            found_d  = !path_lost_d && mark;
            status_d = 1'b0;
            if (!path_lost_d && mark && cmd_q == CMD_DELETE) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, child};
            end
          end
          cur_d        = '0;
          path_lost_d  = 1'b0;
          overflowed_d = 1'b0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      cur_q          <= '0;
      next_free_q    <= FREE_W'(1);
      path_lost_q    <= 1'b0;
      overflowed_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      cur_q          <= cur_d;
      next_free_q    <= next_free_d;
      path_lost_q    <= path_lost_d;
      overflowed_q   <= overflowed_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    status_q <= status_d;
    if (state_q == ST_IDLE && start) begin
      cmd_q  <= command_i;
      last_q <= last_i;
      bad_q  <= letter_bad;
      addr_q <= addr_calc;
    end
  end

  assign result_valid_o = result_valid_q;
  assign found_o        = found_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  a_result_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result beat without a preceding execute cycle");

  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NODES_F)
    else $error("free node counter ran past the pool");

  a_cur_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < NODES)
    else $error("current node outside the pool");

  a_overflow_is_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> found_o)
    else $error("overflow status reported without insert result");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != ST_IDLE)
    else $error("child table written while idle");
`endif

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trie dictionary engine testbench
// Sends words one letter per beat under insert, search and delete commands.
// A local trie model predicts each word's result, and a monitor compares
// every result strobe with the oldest prediction. Phases cover directed
// words, random words at several idle levels, and exhaustion of the pool.
// ----------------------------------------------------------------------------
module testbench;
  import tde_pkg::*;

  localparam int NODES       = 1024;
  localparam int ALPHA       = 26;
  localparam int MAX_LEN     = 10;
  localparam int MAX_GAP     = 60;
  localparam int DRAIN       = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;
  localparam int KNOWN_MAX   = 200;

  // Command code 3 is decoded like a search.
  localparam logic [1:0] CMD_ALT_SEARCH = 2'd3;
  localparam logic [4:0] LETTER_TOP     = 5'd31;
  localparam byte        CHAR_A         = "a";

  typedef struct {
    logic found;
    logic status;
  } result_t;

  typedef struct {
    int         len;
    logic [4:0] ltr [MAX_LEN];
  } word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] command_i;
  logic [4:0] letter_i;
  logic       last_i;
  logic       result_valid_o;
  logic       found_o;
  logic       status_o;

  trie_dictionary_engine #(
    .NODES   (NODES),
    .ALPHABET(ALPHA)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .letter_i      (letter_i),
    .last_i        (last_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .status_o      (status_o)
  );

  // Local copy of the trie.
  int         child_nodes [NODES*ALPHA];
  bit         word_ends   [NODES];
  int         walk_node   = 0;
  int         free_node   = 1;
  bit         walk_lost   = 1'b0;
  bit         walk_ovf    = 1'b0;

  result_t    pending_results [$];
  word_t      known_words [$];
  int         mismatches  = 0;
  int         items_sent  = 0;
  int         idle_level  = 0;
  int         cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void report_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Advances the trie walk by one letter; on the final letter it yields the result.
  function automatic void predict_letter(input logic [1:0] cmd, input logic [4:0] ltr,
                                         input logic lst, output bit has_res,
                                         output result_t res);
    int  slot;
    int  child;
    bit  present;
    has_res    = 1'b0;
    res.found  = 1'b0;
    res.status = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (!walk_ovf) begin
        if (ltr >= ALPHA) begin
          walk_ovf = 1'b1;
        end else begin
          slot  = walk_node * ALPHA + ltr;
          child = child_nodes[slot];
          if (child == 0) begin
            if (free_node >= NODES) begin
              walk_ovf = 1'b1;
            end else begin
              child             = free_node;
              child_nodes[slot] = child;
              free_node++;
            end
          end
          if (!walk_ovf) walk_node = child;
        end
      end
    end else if (!walk_lost) begin
      if (ltr >= ALPHA) begin
        walk_lost = 1'b1;
      end else begin
        child = child_nodes[walk_node * ALPHA + ltr];
        if (child == 0) walk_lost = 1'b1;
        else walk_node = child;
      end
    end
    if (lst) begin
      has_res = 1'b1;
      if (cmd == CMD_INSERT) begin
        res.found = 1'b1;
        if (walk_ovf) res.status = 1'b1;
        else word_ends[walk_node] = 1'b1;
      end else begin
        present = !walk_lost && word_ends[walk_node];
        if (present && cmd == CMD_DELETE) word_ends[walk_node] = 1'b0;
        res.found = present;
      end
      walk_node = 0;
      walk_lost = 1'b0;
      walk_ovf  = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with none expected: found=%b status=%b",
                               found_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found || status_o !== want.status)
          report_error($sformatf("expected found=%b status=%b, got found=%b status=%b",
                                 want.found, want.status, found_o, status_o));
      end
    end
  end

  // One letter beat. The start line stays high between back-to-back beats.
  task automatic send_letter(input logic [1:0] cmd, input logic [4:0] ltr,
                             input logic lst);
    int      gap;
    bit      has_res;
    result_t res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_level) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd;
    letter_i  <= ltr;
    last_i    <= lst;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_letter(cmd, ltr, lst, has_res, res);
    if (has_res) pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_word(input word_t w, input logic [1:0] cmd);
    for (int i = 0; i < w.len; i++) send_letter(cmd, w.ltr[i], i == w.len - 1);
  endtask

  function automatic word_t spell(string s);
    word_t w;
    w.len = s.len();
    for (int i = 0; i < MAX_LEN; i++) w.ltr[i] = '0;
    for (int i = 0; i < w.len; i++) w.ltr[i] = 5'(s[i] - CHAR_A);
    return w;
  endfunction

  // A narrow word draws mostly from four letters so that paths get shared.
  function automatic word_t make_word(int min_len, int max_len, bit narrow, bit allow_bad);
    word_t w;
    w.len = $urandom_range(max_len, min_len);
    for (int i = 0; i < MAX_LEN; i++) begin
      if (allow_bad && $urandom_range(99) < 2) w.ltr[i] = 5'($urandom_range(31, ALPHA));
      else if (narrow && $urandom_range(99) < 70) w.ltr[i] = 5'($urandom_range(3));
      else w.ltr[i] = 5'($urandom_range(ALPHA - 1));
    end
    return w;
  endfunction

  function automatic void remember(word_t w);
    known_words.push_back(w);
    if (known_words.size() > KNOWN_MAX) void'(known_words.pop_front());
  endfunction

  task automatic test_directed();
    word_t w;
    idle_level = 0;
    send_word(spell("a"), CMD_SEARCH);
    send_word(spell("a"), CMD_INSERT);
    send_word(spell("a"), CMD_SEARCH);
    send_word(spell("zz"), CMD_INSERT);
    send_word(spell("z"), CMD_SEARCH);
    send_word(spell("zz"), CMD_SEARCH);
    send_word(spell("zz"), CMD_DELETE);
    send_word(spell("zz"), CMD_DELETE);
    send_word(spell("zz"), CMD_SEARCH);
    // A letter beyond the alphabet drops an insert and loses a search path.
    w        = spell("bb");
    w.ltr[1] = LETTER_TOP;
    send_word(w, CMD_INSERT);
    send_letter(CMD_SEARCH, 5'(ALPHA), 1'b1);
    send_word(spell("a"), CMD_ALT_SEARCH);
    // The command may change in the middle of a word.
    send_letter(CMD_INSERT, 5'd2, 1'b0);
    send_letter(CMD_SEARCH, 5'd3, 1'b1);
    send_word(spell("q"), CMD_DELETE);
  endtask

  task automatic test_random_words(int budget, int idle_pct);
    int    first;
    int    pick;
    word_t w;
    idle_level = idle_pct;
    first      = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(99);
      if (known_words.size() > 0 && $urandom_range(1) == 1)
        w = known_words[$urandom_range(known_words.size() - 1)];
      else
        w = make_word(1, 6, 1'b1, 1'b1);
      if (pick < 40) begin
        send_word(w, CMD_INSERT);
        remember(w);
      end else if (pick < 72) begin
        send_word(w, ($urandom_range(4) == 0) ? CMD_ALT_SEARCH : CMD_SEARCH);
      end else if (pick < 90) begin
        send_word(w, CMD_DELETE);
      end else if (pick < 95) begin
        // Update: remove the word, then put it back.
        send_word(w, CMD_DELETE);
        send_word(w, CMD_INSERT);
      end else begin
        for (int i = 0; i < w.len; i++)
          send_letter(2'($urandom_range(3)), w.ltr[i], i == w.len - 1);
      end
    end
  endtask

  task automatic test_pool_exhaustion();
    int    full_words;
    word_t w;
    idle_level = 0;
    full_words = 0;
    while (full_words < 6) begin
      w = make_word(6, MAX_LEN, 1'b0, 1'b0);
      if (free_node >= NODES) full_words++;
      send_word(w, CMD_INSERT);
      remember(w);
    end
    // Words on existing paths still go in once the pool is used up.
    for (int i = 0; i < 12; i++) begin
      w = known_words[$urandom_range(known_words.size() - 1)];
      send_word(w, ($urandom_range(1) == 1) ? CMD_SEARCH : CMD_INSERT);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    command_i = CMD_INSERT;
    letter_i  = '0;
    last_i    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_words(400, 0);
    test_random_words(400, 80);
    test_random_words(300, 19);
    test_pool_exhaustion();
    test_random_words(150, 19);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/tde_pkg.sv
sv/tde_ram.sv
sv/trie_dictionary_engine.sv
sim/testbench.sv
